### rtl/psr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_pkg : shared types, constants and rank lookup
// Sizes of the item store, class buckets and rank levels, the item record
// that crosses the queue, and the class-to-rank lookup used by the sorter.
// ----------------------------------------------------------------------------
package psr_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int NUM_CLASSES = 24;

   localparam int TAG_W    = 16;
   localparam int CLASS_W  = 5;
   localparam int RANK_W   = 5;
   localparam int RANK_LEVELS = 1 << RANK_W;
   localparam int HALF_TABLE_W = 60;
   localparam int TABLE_W  = 2 * HALF_TABLE_W;
   localparam int OLEN_W   = 5;

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   // one bucket per class, plus one for codes outside the class range
   localparam int NUM_BUCKETS = NUM_CLASSES + 1;
   localparam int BKT_W = $clog2(NUM_BUCKETS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [RANK_W-1:0] RANK_UNLISTED = '1;

   // configuration register map (paddr[4:3])
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [1:0] REG_RANK_LOW  = 2'd0;
   localparam logic [1:0] REG_RANK_HIGH = 2'd1;
   localparam logic [1:0] REG_ORDER_LEN = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [CLASS_W-1:0] cls;
   } psr_entry_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [CLASS_W-1:0] cls;
      logic [BKT_W-1:0]   bucket;
      logic               last;
   } psr_item_type;

   typedef struct packed {
      logic             loading;
      logic [CNT_W-1:0] count;
   } psr_status_type;

   function automatic logic [RANK_W-1:0] rank_of(
      input logic [CLASS_W-1:0] cls,
      input logic [TABLE_W-1:0] tbl,
      input logic [OLEN_W-1:0]  olen
   );
      logic [RANK_W-1:0] r;
      r = RANK_W'(olen);
      if (cls < CLASS_W'(NUM_CLASSES)) begin
         r = tbl[cls*RANK_W +: RANK_W];
         if (r == RANK_UNLISTED) begin
            r = RANK_W'(olen);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/psr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_front : input stage
// Registers each request beat, sorts its class code into a bucket (codes
// outside the class range share one bucket) and pushes it into the queue.
// ----------------------------------------------------------------------------
module psr_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [psr_pkg::REQ_DATA_W-1:0] req_tdata,  // tag[15:0], class[20:16]
   input  wire logic                           req_tlast,
   output logic                                q_push,
   output psr_pkg::psr_item_type               q_item,
   input  wire logic                           q_ready
);

   logic                  valid_ff, valid_in;
   psr_pkg::psr_item_type item_ff, item_in;
   logic [psr_pkg::CLASS_W-1:0] cls;

   assign cls        = req_tdata[psr_pkg::TAG_W +: psr_pkg::CLASS_W];
   assign req_tready = !valid_ff || q_ready;
   assign q_push     = valid_ff;
   assign q_item     = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in       = req_tvalid;
         item_in.tag    = req_tdata[psr_pkg::TAG_W-1:0];
         item_in.cls    = cls;
         item_in.last   = req_tlast;
         if (cls < psr_pkg::CLASS_W'(psr_pkg::NUM_CLASSES)) begin
            item_in.bucket = psr_pkg::BKT_W'(cls);
         end else begin
            item_in.bucket = psr_pkg::BKT_W'(psr_pkg::NUM_CLASSES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

### rtl/psr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_queue : short item queue
// Small FIFO between the input stage and the sorter so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module psr_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire psr_pkg::psr_item_type push_item,
   output logic                       push_ready,
   output logic                       pop_valid,
   output psr_pkg::psr_item_type      pop_item,
   input  wire logic                  pop_ready
);

   psr_pkg::psr_item_type       slot_ff [psr_pkg::QUEUE_DEPTH];
   logic [psr_pkg::QPTR_W-1:0]  wr_ff, wr_in;
   logic [psr_pkg::QPTR_W-1:0]  rd_ff, rd_in;
   logic [psr_pkg::QCNT_W-1:0]  fill_ff, fill_in;
   logic                        do_push, do_pop;

   assign push_ready = fill_ff != psr_pkg::QCNT_W'(psr_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_item   = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == psr_pkg::QPTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == psr_pkg::QPTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### rtl/psr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_back : batch store and counting sorter
// Loads a batch into the item store with per-bucket counts, then builds a
// rank histogram, turns it into start offsets, scatters the batch into the
// sorted store and streams that store out through an output register.
// ----------------------------------------------------------------------------
module psr_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [psr_pkg::TABLE_W-1:0]     rank_table,
   input  wire logic [psr_pkg::OLEN_W-1:0]      order_length,
   input  wire logic                            q_valid,
   input  wire psr_pkg::psr_item_type           q_item,
   output logic                                 q_ready,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [psr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   output psr_pkg::psr_status_type              status
);

   typedef enum logic [4:0] {
      ST_LOAD    = 5'b00001,
      ST_HIST    = 5'b00010,
      ST_PREFIX  = 5'b00100,
      ST_SCATTER = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [psr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic [psr_pkg::BKT_W-1:0]  bkt_ff, bkt_in;
   logic [psr_pkg::RANK_W-1:0] rnk_ff, rnk_in;
   logic [psr_pkg::CNT_W-1:0]  acc_ff, acc_in;
   logic [psr_pkg::CNT_W-1:0]  ptr_ff, ptr_in;
   logic                       pend_ff, pend_in;
   logic [psr_pkg::CNT_W-1:0]  cls_cnt_ff [psr_pkg::NUM_BUCKETS];
   logic [psr_pkg::CNT_W-1:0]  cls_cnt_in [psr_pkg::NUM_BUCKETS];
   logic [psr_pkg::CNT_W-1:0]  rank_ff [psr_pkg::RANK_LEVELS];
   logic [psr_pkg::CNT_W-1:0]  rank_in [psr_pkg::RANK_LEVELS];

   psr_pkg::psr_entry_type     store_mem [psr_pkg::MAX_ITEMS];
   psr_pkg::psr_entry_type     sorted_mem [psr_pkg::MAX_ITEMS];
   psr_pkg::psr_entry_type     st_rd_ff, so_rd_ff;
   logic                       rd_last_ff;

   logic                       out_valid_ff, out_valid_in;
   psr_pkg::psr_entry_type     out_ent_ff;
   logic                       out_last_ff, out_ovf_ff;

   logic                       pop, store_we, store_re, sorted_we, sorted_re;
   logic                       out_free, load_out, issue;
   logic [psr_pkg::IDX_W-1:0]  sorted_addr;
   logic [psr_pkg::RANK_W-1:0] hist_rank, sc_rank;

   assign q_ready   = state_ff == ST_LOAD;
   assign pop       = q_ready && q_valid;
   assign store_we  = pop && (count_ff < psr_pkg::CNT_W'(psr_pkg::MAX_ITEMS));
   assign out_free  = !out_valid_ff || rsp_tready;
   assign hist_rank = psr_pkg::rank_of(psr_pkg::CLASS_W'(bkt_ff), rank_table, order_length);
   assign sc_rank   = psr_pkg::rank_of(st_rd_ff.cls, rank_table, order_length);
   assign sorted_addr = rank_ff[sc_rank][psr_pkg::IDX_W-1:0];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_ovf_ff, out_ent_ff.cls, out_ent_ff.tag};
   assign status.loading = state_ff == ST_LOAD;
   assign status.count   = count_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      bkt_in     = bkt_ff;
      rnk_in     = rnk_ff;
      acc_in     = acc_ff;
      ptr_in     = ptr_ff;
      pend_in    = pend_ff;
      cls_cnt_in = cls_cnt_ff;
      rank_in    = rank_ff;
      store_re   = 1'b0;
      sorted_we  = 1'b0;
      sorted_re  = 1'b0;
      load_out   = 1'b0;
      issue      = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (store_we) begin
                  count_in = count_ff + 1'b1;
                  cls_cnt_in[q_item.bucket] = cls_cnt_ff[q_item.bucket] + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (q_item.last) begin
                  state_in = ST_HIST;
                  bkt_in   = '0;
                  for (int r = 0; r < psr_pkg::RANK_LEVELS; r++) begin
                     rank_in[r] = '0;
                  end
               end
            end
         end
         ST_HIST: begin
            rank_in[hist_rank] = rank_ff[hist_rank] + cls_cnt_ff[bkt_ff];
            bkt_in = bkt_ff + 1'b1;
            if (bkt_ff == psr_pkg::BKT_W'(psr_pkg::NUM_BUCKETS - 1)) begin
               state_in = ST_PREFIX;
               rnk_in   = '0;
               acc_in   = '0;
            end
         end
         ST_PREFIX: begin
            // replace each count by the offset of its rank
            rank_in[rnk_ff] = acc_ff;
            acc_in = acc_ff + rank_ff[rnk_ff];
            rnk_in = rnk_ff + 1'b1;
            if (rnk_ff == psr_pkg::RANK_W'(psr_pkg::RANK_LEVELS - 1)) begin
               state_in = ST_SCATTER;
               ptr_in   = '0;
               pend_in  = 1'b0;
            end
         end
         ST_SCATTER: begin
            issue    = ptr_ff < count_ff;
            store_re = issue;
            pend_in  = issue;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               sorted_we = 1'b1;
               rank_in[sc_rank] = rank_ff[sc_rank] + 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_EMIT;
               ptr_in   = '0;
               pend_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            load_out  = pend_ff && out_free;
            issue     = (ptr_ff < count_ff) && (!pend_ff || out_free);
            sorted_re = issue;
            pend_in   = issue || (pend_ff && !out_free);
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_LOAD;
               count_in = '0;
               for (int b = 0; b < psr_pkg::NUM_BUCKETS; b++) begin
                  cls_cnt_in[b] = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int b = 0; b < psr_pkg::NUM_BUCKETS; b++) begin
            cls_cnt_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         cls_cnt_ff   <= cls_cnt_in;
      end
      bkt_ff  <= bkt_in;
      rnk_ff  <= rnk_in;
      acc_ff  <= acc_in;
      ptr_ff  <= ptr_in;
      rank_ff <= rank_in;
      if (load_out) begin
         out_ent_ff  <= so_rd_ff;
         out_last_ff <= rd_last_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   // item store: written in arrival order, read during the scatter
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[psr_pkg::IDX_W-1:0]] <= '{tag: q_item.tag, cls: q_item.cls};
      end
      if (store_re) begin
         st_rd_ff <= store_mem[ptr_ff[psr_pkg::IDX_W-1:0]];
      end
   end

   // sorted store: written at rank offsets, read out in order
   always_ff @(posedge clock) begin
      if (sorted_we) begin
         sorted_mem[sorted_addr] <= st_rd_ff;
      end
      if (sorted_re) begin
         so_rd_ff   <= sorted_mem[ptr_ff[psr_pkg::IDX_W-1:0]];
         rd_last_ff <= ptr_ff == (count_ff - 1'b1);
      end
   end

endmodule
`default_nettype wire

### rtl/priority_stable_reorder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_stable_reorder_top : stable batch reorder by class rank
// Collects a batch of tagged items and returns it sorted by class rank.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one item a beat (tag, class); tlast closes the batch.
//    Up to 64 items are kept; later ones are dropped and a sticky overflow
//    bit is raised, reported on every result beat until reset.
//  - rsp_* returns the batch sorted by rank, equal ranks in arrival order,
//    with tlast on the final beat.
//  - csr_* is an APB port: rank tables for classes 0-11 and 12-23 at 0x00
//    and 0x08 (5 bits a class, 31 = unlisted), order length at 0x10.
//  - Loading takes one item a cycle. After the closing beat the sorter
//    counts buckets into a rank histogram, builds the rank offsets and
//    scatters the batch into the sorted store, then streams one beat a
//    cycle while rsp_tready stays high.
//  - While a batch is sorted or emitted, input beats wait in a 4-entry queue
//    and then back up into req_tready.
//  - A stall on rsp_tready holds the output register and pauses emission.
//  - Reset empties the batch, clears the overflow bit and sets every class
//    unlisted with order length 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_stable_reorder_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [psr_pkg::REQ_DATA_W-1:0]    req_tdata,  // item_tag[15:0], item_class[20:16]
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [psr_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // out_tag[15:0], out_class[20:16],
                                                              // overflowed[21]
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [psr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [psr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [psr_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   logic [psr_pkg::HALF_TABLE_W-1:0] rank_low_ff, rank_low_in;
   logic [psr_pkg::HALF_TABLE_W-1:0] rank_high_ff, rank_high_in;
   logic [psr_pkg::OLEN_W-1:0]       olen_ff, olen_in;
   logic                             csr_wr;

   logic                    q_push, q_push_ready, q_valid, q_ready, q_pop;
   psr_pkg::psr_item_type   q_in_item, q_out_item;
   psr_pkg::psr_status_type back_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rank_low_in  = rank_low_ff;
      rank_high_in = rank_high_ff;
      olen_in      = olen_ff;
      csr_prdata   = '0;
      unique case (csr_paddr[4:3])
         psr_pkg::REG_RANK_LOW: begin
            csr_prdata = psr_pkg::CSR_DATA_W'(rank_low_ff);
            if (csr_wr) rank_low_in = csr_pwdata[psr_pkg::HALF_TABLE_W-1:0];
         end
         psr_pkg::REG_RANK_HIGH: begin
            csr_prdata = psr_pkg::CSR_DATA_W'(rank_high_ff);
            if (csr_wr) rank_high_in = csr_pwdata[psr_pkg::HALF_TABLE_W-1:0];
         end
         psr_pkg::REG_ORDER_LEN: begin
            csr_prdata = psr_pkg::CSR_DATA_W'(olen_ff);
            if (csr_wr) olen_in = csr_pwdata[psr_pkg::OLEN_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_low_ff  <= '1;
         rank_high_ff <= '1;
         olen_ff      <= '0;
      end else begin
         rank_low_ff  <= rank_low_in;
         rank_high_ff <= rank_high_in;
         olen_ff      <= olen_in;
      end
   end

   psr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_push     (q_push),
      .q_item     (q_in_item),
      .q_ready    (q_push_ready)
   );

   psr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .push_ready (q_push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_out_item),
      .pop_ready  (q_ready)
   );

   psr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .rank_table   ({rank_high_ff, rank_low_ff}),
      .order_length (olen_ff),
      .q_valid      (q_valid),
      .q_item       (q_out_item),
      .q_ready      (q_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .status       (back_stat)
   );

   assign q_pop = q_valid && q_ready;

   a_no_pop_while_sorting: assert property (@(posedge clock) disable iff (reset)
      !back_stat.loading |-> !q_pop)
      else $error("queue popped while the sorter is busy");

   a_batch_end_starts_sort: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_out_item.last |=> !back_stat.loading)
      else $error("closing beat did not start the sort");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      back_stat.count <= psr_pkg::CNT_W'(psr_pkg::MAX_ITEMS))
      else $error("item count beyond store capacity");

endmodule
`default_nettype wire
